### rtl/bgpio_pkg.sv
// Banked GPIO pin controller: shared types and constants.
// Holds the operation codes, field types and the fixed pin range table.
// No dependencies.
package bgpio_pkg;

  typedef logic [2:0]  mode_t;
  typedef logic [7:0]  pin_t;
  typedef logic [31:0] word_t;

  // Operation codes
  localparam mode_t MODE_WRPIN      = 3'd0;
  localparam mode_t MODE_RDPIN      = 3'd1;
  localparam mode_t MODE_GETPINDIR  = 3'd2;
  localparam mode_t MODE_SETPINDIR  = 3'd3;
  localparam mode_t MODE_WRBANK     = 3'd4;
  localparam mode_t MODE_RDBANK     = 3'd5;
  localparam mode_t MODE_GETBANKDIR = 3'd6;
  localparam mode_t MODE_SETBANKDIR = 3'd7;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Global pin ranges, one per bank
  localparam int   RANGE_COUNT = 4;
  localparam pin_t RANGE_LO [RANGE_COUNT] = '{8'd0,  8'd32, 8'd54, 8'd86};
  localparam pin_t RANGE_HI [RANGE_COUNT] = '{8'd31, 8'd53, 8'd85, 8'd117};

endpackage

### rtl/banked_gpio_pin_controller_top.sv
// Banked GPIO pin controller, top level.
// Holds the input stage, the bank registers and the result stage.
// Depends on bgpio_pkg.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+----------------------------------------------
//   in_      | in  | in_valid/in_stall  | mode, pin, bank_sel, value, pad_levels
//   out_     | out | out_valid/out_stall| status, read_value, bank_index,
//            |     |                    | drive_data, drive_enable
//
// One transaction is accepted per cycle when the result side keeps up. The input
// register takes an accepted transaction, and when that transaction advances, the
// bank read-modify-write fills the result register, which presents the result.
// Reset (rst_n low, synchronous) clears both stage valids and all bank registers.
// A stall on the result side holds the result register; in_stall rises only
// when the input register is also full and cannot advance.
module banked_gpio_pin_controller_top #(
  parameter int NUM_BANKS  = 4,
  parameter int BANK_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  bgpio_pkg::mode_t       in_mode,
  input  bgpio_pkg::pin_t        in_pin,
  input  logic [7:0]             in_bank_sel,
  input  bgpio_pkg::word_t       in_value,
  input  bgpio_pkg::word_t       in_pad_levels,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_status,
  output bgpio_pkg::word_t       out_read_value,
  output logic [1:0]             out_bank_index,
  output bgpio_pkg::word_t       out_drive_data,
  output bgpio_pkg::word_t       out_drive_enable
);

  localparam int BANK_IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int POS_W      = (BANK_WIDTH > 1) ? $clog2(BANK_WIDTH) : 1;

  typedef logic [BANK_WIDTH-1:0] bank_word_t;

  // ---------------------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_load, s2_take, s2_load, out_done;

  assign out_done = out_valid_r && !out_stall;
  assign s2_take  = !out_valid_r || !out_stall;
  assign s2_load  = s1_valid_r && s2_take;
  assign in_stall = s1_valid_r && !s2_take;
  assign s1_load  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_done) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: hold the transaction until the result stage takes it
  // ---------------------------------------------------------------------------
  bgpio_pkg::mode_t s1_mode_r;
  bgpio_pkg::pin_t  s1_pin_r;
  logic [7:0]       s1_bank_sel_r;
  bgpio_pkg::word_t s1_value_r;
  bgpio_pkg::word_t s1_pads_r;

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_mode_r     <= in_mode;
      s1_pin_r      <= in_pin;
      s1_bank_sel_r <= in_bank_sel;
      s1_value_r    <= in_value;
      s1_pads_r     <= in_pad_levels;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode: map the pin or bank number onto a bank and a bit position
  // ---------------------------------------------------------------------------
  logic       pin_op;
  logic       addr_ok;
  logic       pin_found;
  logic [7:0] bank8;
  logic [7:0] pos8;

  assign pin_op = s1_mode_r inside {bgpio_pkg::MODE_WRPIN, bgpio_pkg::MODE_RDPIN,
                                    bgpio_pkg::MODE_GETPINDIR,
                                    bgpio_pkg::MODE_SETPINDIR};

  always_comb begin
    addr_ok   = 1'b0;
    pin_found = 1'b0;
    bank8     = '0;
    pos8      = '0;
    if (pin_op) begin
      // Ranges are disjoint; stop at the first hit.
      for (int i = 0; i < bgpio_pkg::RANGE_COUNT; i++) begin
        if (!pin_found && (i < NUM_BANKS) &&
            (s1_pin_r >= bgpio_pkg::RANGE_LO[i]) &&
            (s1_pin_r <= bgpio_pkg::RANGE_HI[i])) begin
          pin_found = 1'b1;
          pos8      = s1_pin_r - bgpio_pkg::RANGE_LO[i];
          bank8     = 8'(i);
          addr_ok   = (32'(pos8) < BANK_WIDTH);
        end
      end
    end else begin
      addr_ok = (32'(s1_bank_sel_r) < NUM_BANKS);
      bank8   = addr_ok ? s1_bank_sel_r : 8'd0;
    end
  end

  logic [BANK_IDX_W-1:0] bank_idx;
  logic [POS_W-1:0]      pos;
  bank_word_t            bit_mask;
  logic                  val_set;

  assign bank_idx = bank8[BANK_IDX_W-1:0];
  assign pos      = pos8[POS_W-1:0];
  assign bit_mask = bank_word_t'(1) << pos;
  assign val_set  = (s1_value_r != '0);

  // ---------------------------------------------------------------------------
  // Bank registers. The output enable register always takes the same word as
  // the direction register, so one array serves both.
  // ---------------------------------------------------------------------------
  bank_word_t data_r [NUM_BANKS];
  bank_word_t dir_r  [NUM_BANKS];
  bank_word_t cur_data, cur_dir;
  bank_word_t data_nxt, dir_nxt;
  bank_word_t pads;
  bgpio_pkg::word_t rd_word;

  assign cur_data = data_r[bank_idx];
  assign cur_dir  = dir_r[bank_idx];
  assign pads     = s1_pads_r[BANK_WIDTH-1:0];

  always_comb begin
    data_nxt = cur_data;
    dir_nxt  = cur_dir;
    rd_word  = '0;
    case (s1_mode_r)
      bgpio_pkg::MODE_WRPIN: begin
        data_nxt = (cur_data & ~bit_mask) | (val_set ? bit_mask : '0);
      end
      bgpio_pkg::MODE_RDPIN: begin
        rd_word = 32'((pads & bit_mask) != '0);
      end
      bgpio_pkg::MODE_GETPINDIR: begin
        rd_word = 32'((cur_dir & bit_mask) != '0);
      end
      bgpio_pkg::MODE_SETPINDIR: begin
        dir_nxt = (cur_dir & ~bit_mask) | (val_set ? bit_mask : '0);
      end
      bgpio_pkg::MODE_WRBANK: begin
        data_nxt = s1_value_r[BANK_WIDTH-1:0];
      end
      bgpio_pkg::MODE_RDBANK: begin
        rd_word = 32'(pads);
      end
      bgpio_pkg::MODE_GETBANKDIR: begin
        rd_word = 32'(cur_dir);
      end
      bgpio_pkg::MODE_SETBANKDIR: begin
        dir_nxt = s1_value_r[BANK_WIDTH-1:0];
      end
      default: begin
        rd_word = '0;
      end
    endcase
  end

  // Commit the read-modify-write only for a valid address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        data_r[b] <= '0;
        dir_r[b]  <= '0;
      end
    end else if (s2_load && addr_ok) begin
      data_r[bank_idx] <= data_nxt;
      dir_r[bank_idx]  <= dir_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: an invalid address gives the error status, all else zero
  // ---------------------------------------------------------------------------
  logic             status_r, status_nxt;
  bgpio_pkg::word_t read_value_r, read_value_nxt;
  logic [1:0]       bank_index_r, bank_index_nxt;
  bgpio_pkg::word_t drive_data_r, drive_data_nxt;
  bgpio_pkg::word_t drive_enable_r, drive_enable_nxt;

  always_comb begin
    status_nxt       = addr_ok ? bgpio_pkg::STATUS_OK : bgpio_pkg::STATUS_ERR;
    read_value_nxt   = addr_ok ? rd_word : '0;
    bank_index_nxt   = addr_ok ? bank8[1:0] : 2'd0;
    drive_data_nxt   = addr_ok ? 32'(data_nxt) : '0;
    drive_enable_nxt = addr_ok ? 32'(dir_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      status_r       <= status_nxt;
      read_value_r   <= read_value_nxt;
      bank_index_r   <= bank_index_nxt;
      drive_data_r   <= drive_data_nxt;
      drive_enable_r <= drive_enable_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_read_value   = read_value_r;
  assign out_bank_index   = bank_index_r;
  assign out_drive_data   = drive_data_r;
  assign out_drive_enable = drive_enable_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == bgpio_pkg::STATUS_ERR)) |->
      (read_value_r == '0 && bank_index_r == 2'd0 &&
       drive_data_r == '0 && drive_enable_r == '0))
    else $error("error result carries non-zero fields");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> out_valid_r)
    else $error("advanced transaction produced no result");

  a_invalid_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && !addr_ok) |=> (data_r[0] == $past(data_r[0]) &&
                               dir_r[0] == $past(dir_r[0])))
    else $error("invalid address changed bank registers");

endmodule
